// ===== rtl/sync_word_length_deframer_macros.svh =====
// Assertion macros shared by the deframer checker.
`ifndef SYNC_WORD_LENGTH_DEFRAMER_MACROS_SVH
`define SYNC_WORD_LENGTH_DEFRAMER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SWLD_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("deframer check failed");

// Next-cycle implication, disabled while reset is asserted.
`define SWLD_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("deframer check failed");

`endif

// ===== rtl/swld_pkg.sv =====
// Types and constants of the sync word / length field deframer.
`default_nettype none
package swld_pkg;

    // Payload of one input transfer.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       link_error;
    } in_t;

    // Payload of one result transfer.
    typedef struct packed {
        logic [7:0] out_byte;
        logic       first_flag;
        logic       last_flag;
        logic [1:0] frame_status;
    } out_t;

    // Control handed to every cell of the sync window.
    typedef struct packed {
        logic shift;
        logic clear;
    } cell_ctl_t;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_SHORT    = 2'd1;
    localparam logic [1:0] STATUS_OVERSIZE = 2'd2;
    localparam logic [1:0] STATUS_ABORT    = 2'd3;

    localparam int LENGTH_OFFSET = 36;
    localparam int HDR_BYTES     = LENGTH_OFFSET + 4;
    localparam logic [31:0] MAX_BYTES_RESET = 32'd1048576;

    localparam int SYNC_MAX  = 32;
    localparam int SyncIdxW  = $clog2(SYNC_MAX);

    // The sync word, padded with zeros to the widest supported length.
    localparam logic [7:0] SYNC_WORD [SYNC_MAX] = '{
        8'h53, 8'h54, 8'h52, 8'h45, 8'h41, 8'h4D, 8'h70, 8'h61,
        8'h63, 8'h6B, 8'h49, 8'h44, 8'h76, 8'h31, 8'h2E, 8'h30,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
    };

endpackage
`default_nettype wire

// ===== rtl/swld_cell.sv =====
// One byte cell of the sync window: holds a byte and compares it to its sync character.
`default_nettype none
module swld_cell #(
    parameter logic [7:0] EXPECT = 8'h00
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire swld_pkg::cell_ctl_t ctl,
    input  wire logic [7:0]          din,
    output logic [7:0]               dout,
    output logic                     hit
);

    logic [7:0] data_reg;
    logic [7:0] data_next;

    always_comb begin
        data_next = data_reg;
        if (ctl.clear) begin
            data_next = 8'h00;
        end else if (ctl.shift) begin
            data_next = din;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            data_reg <= 8'h00;
        end else begin
            data_reg <= data_next;
        end
    end

    assign dout = data_reg;
    assign hit  = (data_reg == EXPECT);

endmodule
`default_nettype wire

// ===== rtl/sync_word_length_deframer.sv =====
// A forwarded byte appears in the output register in the cycle after its transfer.
// Throughput: one byte per cycle while m_ready does not stall; a sync match holds s_ready low
// while the rest of the sync word drains one byte per cycle through the output register.
// Reset (aresetn low, synchronous): window cells cleared, hunting, counters zero,
// output empty, max_packet_bytes back to 1048576.
`default_nettype none
module sync_word_length_deframer #(
    parameter int SYNC_BYTES = 16
) (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    // Input byte channel.
    input  wire logic           s_valid,
    output logic                s_ready,
    input  wire swld_pkg::in_t  s_data,
    // Result channel.
    output logic                m_valid,
    input  wire logic           m_ready,
    output swld_pkg::out_t      m_data,
    // Configuration: max_packet_bytes.
    input  wire logic           cfg_wr_en,
    input  wire logic [31:0]    cfg_wr_data
);

    // The window keeps the last SYNC_BYTES-1 bytes; the incoming byte completes the match.
    localparam int WinDepth = SYNC_BYTES - 1;
    localparam int IdxW     = (SYNC_BYTES > 1) ? $clog2(SYNC_BYTES) : 1;

    logic                   collecting_reg, collecting_next;
    logic [31:0]            pos_reg, pos_next;
    logic [31:0]            len_reg, len_next;
    logic [31:0]            max_reg;
    logic                   burst_active_reg, burst_active_next;
    logic [IdxW-1:0]        burst_idx_reg, burst_idx_next;
    logic                   m_valid_reg, m_valid_next;
    swld_pkg::out_t         m_data_reg, m_data_next;

    logic                   s_accept;
    logic                   advance;
    logic                   hunt_take;
    logic                   coll_take;
    logic                   window_match;
    logic                   byte_match;
    logic                   sync_match;
    swld_pkg::cell_ctl_t    cell_ctl;

    logic [31:0]            len_upd;
    logic                   hdr_end;
    logic                   body_end;
    logic                   pkt_last;
    logic [1:0]             pkt_status;

    // The output register advances when it is empty or its content is being taken.
    // New input is refused while the output register is stalled or the sync word burst is still draining.
    assign advance   = !m_valid_reg || m_ready;
    assign s_ready   = advance && !burst_active_reg;
    assign s_accept  = s_valid && s_ready;
    assign hunt_take = s_accept && !collecting_reg;
    assign coll_take = s_accept && collecting_reg;

    // Sync window: a row of cells shifting toward index 0, the oldest byte.
    // Cells are cleared on a match and on a link error; while collecting they stay
    // cleared, so packet bytes never take part in the next hunt.
    assign byte_match = (s_data.data_byte == swld_pkg::SYNC_WORD[SYNC_BYTES - 1]);
    assign sync_match = hunt_take && !s_data.link_error && window_match && byte_match;
    assign cell_ctl.clear = hunt_take && (s_data.link_error || sync_match);
    assign cell_ctl.shift = hunt_take && !s_data.link_error && !sync_match;

    generate
        if (SYNC_BYTES > 1) begin : g_win
            logic [7:0]          win_data [WinDepth];
            logic [WinDepth-1:0] win_hit;

            for (genvar i = 0; i < WinDepth; i++) begin : g_cell
                logic [7:0] cell_din;
                if (i == WinDepth - 1) begin : g_tail
                    assign cell_din = s_data.data_byte;
                end else begin : g_mid
                    assign cell_din = win_data[i + 1];
                end
                swld_cell #(
                    .EXPECT (swld_pkg::SYNC_WORD[i])
                ) u_cell (
                    .aclk    (aclk),
                    .aresetn (aresetn),
                    .ctl     (cell_ctl),
                    .din     (cell_din),
                    .dout    (win_data[i]),
                    .hit     (win_hit[i])
                );
            end

            assign window_match = &win_hit;
        end else begin : g_nowin
            // A one-byte sync word is matched by the incoming byte alone.
            assign window_match = 1'b1;
        end
    endgenerate

    // Length field capture: the four little-endian bytes are merged as they pass.
    always_comb begin
        len_upd = len_reg;
        for (int j = 0; j < 4; j++) begin
            if (pos_reg == 32'(swld_pkg::LENGTH_OFFSET + j)) begin
                len_upd[8*j +: 8] = len_reg[8*j +: 8] | s_data.data_byte;
            end
        end
    end

    // The last length byte decides short, oversize and header-only packets.
    // Past the header, the byte whose position plus one equals the length ends the packet.
    assign hdr_end  = (pos_reg == 32'(swld_pkg::HDR_BYTES - 1));
    assign body_end = (pos_reg >= 32'(swld_pkg::HDR_BYTES)) &&
                      (({1'b0, pos_reg} + 33'd1) == {1'b0, len_reg});

    always_comb begin
        pkt_last   = 1'b0;
        pkt_status = swld_pkg::STATUS_OK;
        if (hdr_end) begin
            if (len_upd < 32'(swld_pkg::HDR_BYTES)) begin
                pkt_last   = 1'b1;
                pkt_status = swld_pkg::STATUS_SHORT;
            end else if (len_upd > max_reg) begin
                pkt_last   = 1'b1;
                pkt_status = swld_pkg::STATUS_OVERSIZE;
            end else if (len_upd == 32'(swld_pkg::HDR_BYTES)) begin
                pkt_last   = 1'b1;
            end
        end else if (body_end) begin
            pkt_last = 1'b1;
        end
    end

    // Packet state. A link error while hunting leaves it as it is: already zero.
    always_comb begin
        collecting_next = collecting_reg;
        pos_next        = pos_reg;
        len_next        = len_reg;
        if (sync_match) begin
            collecting_next = 1'b1;
            pos_next        = 32'(SYNC_BYTES);
            len_next        = 32'd0;
        end else if (coll_take) begin
            if (s_data.link_error || pkt_last) begin
                collecting_next = 1'b0;
                pos_next        = 32'd0;
                len_next        = 32'd0;
            end else begin
                pos_next = pos_reg + 32'd1;
                len_next = len_upd;
            end
        end
    end

    // Output register. A match loads the first sync byte and starts the burst,
    // which replays the rest of the sync word from the constant table.
    always_comb begin
        m_valid_next      = m_valid_reg;
        m_data_next       = m_data_reg;
        burst_active_next = burst_active_reg;
        burst_idx_next    = burst_idx_reg;
        if (advance) begin
            if (burst_active_reg) begin
                m_valid_next = 1'b1;
                m_data_next  = '{
                    out_byte:     swld_pkg::SYNC_WORD[swld_pkg::SyncIdxW'(burst_idx_reg)],
                    first_flag:   1'b0,
                    last_flag:    1'b0,
                    frame_status: swld_pkg::STATUS_OK
                };
                burst_idx_next = burst_idx_reg + IdxW'(1);
                if (burst_idx_reg == IdxW'(SYNC_BYTES - 1)) begin
                    burst_active_next = 1'b0;
                end
            end else if (sync_match) begin
                m_valid_next = 1'b1;
                m_data_next  = '{
                    out_byte:     swld_pkg::SYNC_WORD[0],
                    first_flag:   1'b1,
                    last_flag:    1'b0,
                    frame_status: swld_pkg::STATUS_OK
                };
                burst_active_next = (SYNC_BYTES > 1);
                burst_idx_next    = IdxW'(1);
            end else if (coll_take) begin
                m_valid_next = 1'b1;
                if (s_data.link_error) begin
                    m_data_next = '{
                        out_byte:     8'h00,
                        first_flag:   1'b0,
                        last_flag:    1'b1,
                        frame_status: swld_pkg::STATUS_ABORT
                    };
                end else begin
                    m_data_next = '{
                        out_byte:     s_data.data_byte,
                        first_flag:   1'b0,
                        last_flag:    pkt_last,
                        frame_status: pkt_status
                    };
                end
            end else begin
                m_valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            collecting_reg   <= 1'b0;
            pos_reg          <= 32'd0;
            len_reg          <= 32'd0;
            max_reg          <= swld_pkg::MAX_BYTES_RESET;
            burst_active_reg <= 1'b0;
            burst_idx_reg    <= '0;
            m_valid_reg      <= 1'b0;
        end else begin
            collecting_reg   <= collecting_next;
            pos_reg          <= pos_next;
            len_reg          <= len_next;
            burst_active_reg <= burst_active_next;
            burst_idx_reg    <= burst_idx_next;
            m_valid_reg      <= m_valid_next;
            if (cfg_wr_en) begin
                max_reg <= cfg_wr_data;
            end
        end
    end

    // The result payload needs no reset; it is qualified by m_valid_reg.
    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule
`default_nettype wire

// ===== rtl/swld_checker.sv =====
// Port-level checks of the deframer result channel, bound to the top level.
`default_nettype none
`include "sync_word_length_deframer_macros.svh"
module swld_checker (
    input wire logic           aclk,
    input wire logic           aresetn,
    input wire logic           m_valid,
    input wire logic           m_ready,
    input wire swld_pkg::out_t m_data
);

    logic first_ok;
    logic abort_ok;

    // A first result carries the first sync character, ok status and no last mark.
    assign first_ok = !m_data.last_flag && (m_data.frame_status == swld_pkg::STATUS_OK) &&
                      (m_data.out_byte == swld_pkg::SYNC_WORD[0]);
    // An abort marker is a zero byte that closes the packet.
    assign abort_ok = m_data.last_flag && (m_data.out_byte == 8'h00) && !m_data.first_flag;

    // A stalled result stays in place.
    `SWLD_ASSERT_NEXT(a_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_data))

    // The first byte of a packet is the first sync character and never ends it.
    `SWLD_ASSERT_IMPL(a_first, aclk, aresetn, m_valid && m_data.first_flag, first_ok)

    // Only a final result carries a nonzero status.
    `SWLD_ASSERT_IMPL(a_status, aclk, aresetn, m_valid && !m_data.last_flag, m_data.frame_status == swld_pkg::STATUS_OK)

    // The abort marker is a zero byte that closes the packet.
    `SWLD_ASSERT_IMPL(a_abort, aclk, aresetn, m_valid && (m_data.frame_status == swld_pkg::STATUS_ABORT), abort_ok)

endmodule

bind sync_word_length_deframer swld_checker u_swld_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
`default_nettype wire
